@@ hdl/sha1_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-1 package
// Shared types, constants and round helpers for the SHA-1 digest engine.
// ----------------------------------------------------------------------------
package sha1_pkg;

    localparam int FIFO_DEPTH_DEF = 4;

    localparam logic [31:0] IV0 = 32'h67452301;
    localparam logic [31:0] IV1 = 32'hEFCDAB89;
    localparam logic [31:0] IV2 = 32'h98BADCFE;
    localparam logic [31:0] IV3 = 32'h10325476;
    localparam logic [31:0] IV4 = 32'hC3D2E1F0;
    localparam logic [31:0] RK0 = 32'h5A827999;
    localparam logic [31:0] RK1 = 32'h6ED9EBA1;
    localparam logic [31:0] RK2 = 32'h8F1BBCDC;
    localparam logic [31:0] RK3 = 32'hCA62C1D6;
    localparam logic [7:0]  PAD_BYTE = 8'h80;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_byte;
        logic       is_last;
    } in_item_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } out_item_t;

    // Command passed from front to back through the queue.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_byte;
        logic       is_last;
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROUND,
        ST_PAD,
        ST_LEN,
        ST_EMIT
    } eng_state_t;

    function automatic logic [31:0] rotl(input logic [31:0] x, input int unsigned s);
        rotl = (x << s) | (x >> (32 - s));
    endfunction

endpackage

@@ hdl/sha1_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-1 front end
// Accept beats, drop empty non-last items, queue the rest for the engine.
// ----------------------------------------------------------------------------
module sha1_front #(
    parameter int DEPTH = sha1_pkg::FIFO_DEPTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  sha1_pkg::in_item_t in_item,
    input  logic              in_valid,
    output logic              in_ready,
    output sha1_pkg::cmd_t    cmd,
    output logic              cmd_valid,
    input  logic              cmd_ready
);
    import sha1_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    cmd_t            mem_reg [DEPTH];
    logic [AW-1:0]   wr_reg, wr_next, rd_reg, rd_next;
    logic [AW:0]     cnt_reg, cnt_next;
    logic            push, pop, keep;

    assign keep      = in_item.has_byte | in_item.is_last;
    assign in_ready  = (cnt_reg != (AW+1)'(DEPTH));
    assign push      = in_valid & in_ready & keep;
    assign cmd_valid = (cnt_reg != '0);
    assign pop       = cmd_valid & cmd_ready;
    assign cmd       = mem_reg[rd_reg];

    always_comb
    begin
        wr_next  = (push) ? ((wr_reg == AW'(DEPTH-1)) ? '0 : wr_reg + 1'b1) : wr_reg;
        rd_next  = (pop)  ? ((rd_reg == AW'(DEPTH-1)) ? '0 : rd_reg + 1'b1) : rd_reg;
        cnt_next = cnt_reg + {{AW{1'b0}}, push} - {{AW{1'b0}}, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_reg] <= '{data_byte: in_item.data_byte,
                                 has_byte:  in_item.has_byte,
                                 is_last:   in_item.is_last};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

@@ hdl/sha1_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-1 back end
// Pack bytes, run one round per cycle, pad, and stream out the digest.
// ----------------------------------------------------------------------------
module sha1_back (
    input  logic                clk,
    input  logic                rst_n,
    input  sha1_pkg::cmd_t      cmd,
    input  logic                cmd_valid,
    output logic                cmd_ready,
    output sha1_pkg::out_item_t out_item,
    output logic                out_valid,
    input  logic                out_ready
);
    import sha1_pkg::*;

    eng_state_t      state_reg, state_next;
    logic [31:0]     w_reg [16];
    logic [31:0]     h_reg [5];
    logic [31:0]     a_reg, b_reg, c_reg, d_reg, e_reg;
    logic [63:0]     bits_reg;
    logic [6:0]      rnd_reg;
    logic            fin_reg;      // final compression: emit afterwards
    logic            more_reg;     // message ends: pad or length block to come
    logic [2:0]      idx_reg;
    logic            ov_reg;
    out_item_t       ov_item_reg;

    logic [5:0]      pos;
    logic [3:0]      wsel;
    logic [1:0]      bsel;
    logic [31:0]     wi, f, k, t, sched;
    logic            take, round_done, out_free;

    assign pos        = bits_reg[8:3];
    assign wsel       = pos[5:2];
    assign bsel       = pos[1:0];
    assign out_free   = !ov_reg || out_ready;
    assign out_valid  = ov_reg;
    assign out_item   = ov_item_reg;
    assign cmd_ready  = (state_reg == ST_IDLE);
    assign take       = cmd_valid && cmd_ready;
    assign round_done = (rnd_reg == 7'd79);

    always_comb
    begin
        sched = rotl(w_reg[13] ^ w_reg[8] ^ w_reg[2] ^ w_reg[0], 1);
        wi    = (rnd_reg < 7'd16) ? w_reg[0] : sched;
        if (rnd_reg < 7'd20)
        begin
            f = (b_reg & c_reg) | (~b_reg & d_reg);
            k = RK0;
        end
        else if (rnd_reg < 7'd40)
        begin
            f = b_reg ^ c_reg ^ d_reg;
            k = RK1;
        end
        else if (rnd_reg < 7'd60)
        begin
            f = (b_reg & c_reg) | (b_reg & d_reg) | (c_reg & d_reg);
            k = RK2;
        end
        else
        begin
            f = b_reg ^ c_reg ^ d_reg;
            k = RK3;
        end
        t = rotl(a_reg, 5) + f + e_reg + k + wi;
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (take)
                begin
                    if (cmd.has_byte && pos == 6'd63)
                        state_next = ST_ROUND;
                    else if (cmd.is_last)
                        state_next = ST_PAD;
                end
            end
            ST_PAD:   state_next = (pos >= 6'd56) ? ST_ROUND : ST_LEN;
            ST_LEN:   state_next = ST_ROUND;
            ST_ROUND:
            begin
                if (round_done)
                begin
                    if (fin_reg)
                        state_next = ST_EMIT;
                    else if (more_reg)
                        state_next = (pos >= 6'd56) ? ST_LEN : ST_PAD;
                    else
                        state_next = ST_IDLE;
                end
            end
            ST_EMIT:
            begin
                if (out_free && idx_reg == 3'd4)
                    state_next = ST_IDLE;
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            rnd_reg   <= '0;
            fin_reg   <= 1'b0;
            more_reg  <= 1'b0;
            idx_reg   <= '0;
            ov_reg    <= 1'b0;
            bits_reg  <= '0;
            h_reg     <= '{IV0, IV1, IV2, IV3, IV4};
            for (int i = 0; i < 16; i++)
                w_reg[i] <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_EMIT && out_free)
                ov_reg <= 1'b1;
            else if (out_ready)
                ov_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (take && cmd.has_byte)
                    begin
                        w_reg[wsel][8*(3-bsel) +: 8] <= cmd.data_byte;
                        bits_reg <= bits_reg + 64'd8;
                        fin_reg  <= 1'b0;
                        more_reg <= cmd.is_last;
                    end
                    rnd_reg <= '0;
                    {a_reg, b_reg, c_reg, d_reg, e_reg} <=
                        {h_reg[0], h_reg[1], h_reg[2], h_reg[3], h_reg[4]};
                end
                ST_PAD:
                begin
                    w_reg[wsel][8*(3-bsel) +: 8] <= PAD_BYTE;
                    // Length goes in only when the pad leaves room.
                    if (pos < 6'd56)
                    begin
                        fin_reg  <= 1'b0;
                        more_reg <= 1'b1;
                    end
                    else
                    begin
                        fin_reg  <= 1'b0;
                        more_reg <= 1'b1;
                    end
                    rnd_reg <= '0;
                    {a_reg, b_reg, c_reg, d_reg, e_reg} <=
                        {h_reg[0], h_reg[1], h_reg[2], h_reg[3], h_reg[4]};
                end
                ST_LEN:
                begin
                    w_reg[14] <= bits_reg[63:32];
                    w_reg[15] <= bits_reg[31:0];
                    fin_reg   <= 1'b1;
                    more_reg  <= 1'b0;
                    rnd_reg   <= '0;
                    {a_reg, b_reg, c_reg, d_reg, e_reg} <=
                        {h_reg[0], h_reg[1], h_reg[2], h_reg[3], h_reg[4]};
                end
                ST_ROUND:
                begin
                    {a_reg, b_reg, c_reg, d_reg, e_reg} <=
                        {t, a_reg, rotl(b_reg, 30), c_reg, d_reg};
                    if (round_done)
                    begin
                        h_reg[0] <= h_reg[0] + t;
                        h_reg[1] <= h_reg[1] + a_reg;
                        h_reg[2] <= h_reg[2] + rotl(b_reg, 30);
                        h_reg[3] <= h_reg[3] + c_reg;
                        h_reg[4] <= h_reg[4] + d_reg;
                        for (int i = 0; i < 16; i++)
                            w_reg[i] <= '0;
                        rnd_reg <= '0;
                        idx_reg <= '0;
                    end
                    else
                    begin
                        // Rotate the schedule window one word a round.
                        for (int i = 0; i < 15; i++)
                            w_reg[i] <= w_reg[i+1];
                        w_reg[15] <= wi;
                        rnd_reg   <= rnd_reg + 7'd1;
                    end
                end
                ST_EMIT:
                begin
                    if (out_free)
                    begin
                        ov_item_reg.digest_word <= h_reg[idx_reg];
                        ov_item_reg.word_index  <= idx_reg;
                        ov_item_reg.last_word   <= (idx_reg == 3'd4);
                        if (idx_reg == 3'd4)
                        begin
                            h_reg    <= '{IV0, IV1, IV2, IV3, IV4};
                            bits_reg <= '0;
                            idx_reg  <= '0;
                            fin_reg  <= 1'b0;
                            more_reg <= 1'b0;
                        end
                        else
                        begin
                            idx_reg  <= idx_reg + 3'd1;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // A byte that fills the block on a last item: after that compression the
    // position is back at zero, so the pad goes in next; after a pad overflow
    // the position stays at 56 or more and only the length block follows.
endmodule

@@ hdl/sha1_digest_engine_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-1 digest engine, top level
// Byte-stream SHA-1: queue front end, round-per-cycle compression back end.
// ----------------------------------------------------------------------------
//  channel | dir | payload            | handshake
//  in      | in  | in_item_t (byte)   | in_valid / in_ready
//  out     | out | out_item_t (word)  | out_valid / out_ready
//
// Each byte is written in the idle state; a full block adds 80 compression rounds.
// A last item adds the pad step, the length load, 80 or 160 rounds, then 5 beats.
// Reset (rst_n low) restores the initial chaining value and clears the queue.
// The front queue keeps taking beats, until it is full, while the back end
// runs rounds or waits on a stalled output beat.
module sha1_digest_engine_top #(
    parameter int FIFO_DEPTH = sha1_pkg::FIFO_DEPTH_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  sha1_pkg::in_item_t  in_item,
    input  logic                in_valid,
    output logic                in_ready,
    output sha1_pkg::out_item_t out_item,
    output logic                out_valid,
    input  logic                out_ready
);
    import sha1_pkg::*;

    cmd_t cmd;
    logic cmd_valid, cmd_ready;

    sha1_front #(.DEPTH(FIFO_DEPTH)) u_front (
        .clk, .rst_n, .in_item, .in_valid, .in_ready,
        .cmd, .cmd_valid, .cmd_ready
    );

    sha1_back u_back (
        .clk, .rst_n, .cmd, .cmd_valid, .cmd_ready,
        .out_item, .out_valid, .out_ready
    );

endmodule

@@ test/sha1_digest_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-1 digest checker
// Watches both channels, models the byte-stream SHA-1 and compares each
// output beat against the oldest predicted digest word.
// ----------------------------------------------------------------------------
module sha1_digest_checker
    import sha1_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  in_item_t  in_item,
    input  logic      in_valid,
    input  logic      in_ready,
    input  out_item_t out_item,
    input  logic      out_valid,
    input  logic      out_ready,
    output int        fail_count,
    output int        words_pending,
    output int        digests_seen
);

    logic [31:0] hash_state [5];
    logic [31:0] msg_block [16];
    logic [63:0] msg_bits;
    out_item_t   digest_q [$];

    function automatic logic [31:0] rol32(logic [31:0] x, int s);
        return (x << s) | (x >> (32 - s));
    endfunction

    task automatic clear_message();
        hash_state[0] = IV0;
        hash_state[1] = IV1;
        hash_state[2] = IV2;
        hash_state[3] = IV3;
        hash_state[4] = IV4;
        foreach (msg_block[i]) msg_block[i] = '0;
        msg_bits = '0;
    endtask

    task automatic run_rounds();
        logic [31:0] w [16];
        logic [31:0] a, b, c, d, e, f, k, t, wr;
        a = hash_state[0]; b = hash_state[1]; c = hash_state[2];
        d = hash_state[3]; e = hash_state[4];
        foreach (w[i]) w[i] = msg_block[i];
        for (int r = 0; r < 80; r++)
        begin
            if (r < 16)
                wr = w[r];
            else
            begin
                wr = rol32(w[(r - 3) & 15] ^ w[(r - 8) & 15] ^ w[(r - 14) & 15]
                           ^ w[r & 15], 1);
                w[r & 15] = wr;
            end
            if (r < 20)      begin f = (b & c) | (~b & d); k = RK0; end
            else if (r < 40) begin f = b ^ c ^ d; k = RK1; end
            else if (r < 60) begin f = (b & c) | (b & d) | (c & d); k = RK2; end
            else             begin f = b ^ c ^ d; k = RK3; end
            t = rol32(a, 5) + f + e + k + wr;
            e = d; d = c; c = rol32(b, 30); b = a; a = t;
        end
        hash_state[0] += a; hash_state[1] += b; hash_state[2] += c;
        hash_state[3] += d; hash_state[4] += e;
        foreach (msg_block[i]) msg_block[i] = '0;
    endtask

    task automatic put_byte(logic [5:0] pos, logic [7:0] val);
        msg_block[pos[5:2]] |= 32'(val) << ((3 - pos[1:0]) * 8);
    endtask

    task automatic absorb_beat(in_item_t it);
        logic [5:0] pos;
        out_item_t  w;
        if (it.has_byte)
        begin
            pos = msg_bits[8:3];
            put_byte(pos, it.data_byte);
            msg_bits += 64'd8;
            if (pos == 6'd63) run_rounds();
        end
        if (!it.is_last) return;
        pos = msg_bits[8:3];
        put_byte(pos, PAD_BYTE);
        if (pos >= 6'd56) run_rounds();
        msg_block[14] = msg_bits[63:32];
        msg_block[15] = msg_bits[31:0];
        run_rounds();
        for (int i = 0; i < 5; i++)
        begin
            w.digest_word = hash_state[i];
            w.word_index  = 3'(i);
            w.last_word   = (i == 4);
            digest_q.push_back(w);
        end
        clear_message();
    endtask

    assign words_pending = digest_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        out_item_t exp_w;
        int        errs;
        errs = 0;
        if (!rst_n)
        begin
            clear_message();
            digest_q.delete();
            fail_count   <= 0;
            digests_seen <= 0;
        end
        else
        begin
            if (in_valid && in_ready) absorb_beat(in_item);
            if (out_valid && out_ready)
            begin
                if (digest_q.size() == 0)
                begin
                    $error("unexpected output beat %h", out_item);
                    errs++;
                end
                else
                begin
                    exp_w = digest_q.pop_front();
                    if (exp_w.last_word) digests_seen <= digests_seen + 1;
                    if (out_item.digest_word !== exp_w.digest_word)
                    begin
                        $error("digest_word: expected %h, got %h",
                               exp_w.digest_word, out_item.digest_word);
                        errs++;
                    end
                    if (out_item.word_index !== exp_w.word_index)
                    begin
                        $error("word_index: expected %0d, got %0d",
                               exp_w.word_index, out_item.word_index);
                        errs++;
                    end
                    if (out_item.last_word !== exp_w.last_word)
                    begin
                        $error("last_word: expected %b, got %b",
                               exp_w.last_word, out_item.last_word);
                        errs++;
                    end
                end
            end
            if (errs != 0)
                fail_count <= fail_count + errs;
        end
    end

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-1 digest engine testbench
// Feeds byte messages of assorted lengths (padding edges, block boundaries,
// empty messages, stray byteless beats) with random gaps on both channels;
// the checker predicts every digest word and counts mismatches.
// ----------------------------------------------------------------------------
module tb_top;
    import sha1_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    in_item_t  in_item = '0;
    logic      in_valid = 1'b0;
    logic      in_ready;
    out_item_t out_item;
    logic      out_valid;
    logic      out_ready = 1'b0;
    int        fail_count, words_pending, digests_seen;
    int        cycle_no = 0;
    int        beats_sent = 0;
    bit        steady = 1'b0;   // set during the no-gap stretch
    int        boundary_lens [4] = '{55, 56, 63, 64};

    always #10 clk = ~clk;

    sha1_digest_engine_top dut (
        .clk(clk), .rst_n(rst_n),
        .in_item(in_item), .in_valid(in_valid), .in_ready(in_ready),
        .out_item(out_item), .out_valid(out_valid), .out_ready(out_ready)
    );

    sha1_digest_checker chk (
        .clk(clk), .rst_n(rst_n),
        .in_item(in_item), .in_valid(in_valid), .in_ready(in_ready),
        .out_item(out_item), .out_valid(out_valid), .out_ready(out_ready),
        .fail_count(fail_count), .words_pending(words_pending),
        .digests_seen(digests_seen)
    );

    // Run-away guard: far above the slowest correct run.
    always @(posedge clk)
    begin
        cycle_no <= cycle_no + 1;
        if (cycle_no > CYCLE_LIMIT)
        begin
            $display("tb_top: errors");
            $finish;
        end
    end

    // Receiver: drop ready in roughly a quarter of cycles, unless steady.
    always @(negedge clk)
        out_ready <= steady || ($urandom_range(99) >= 26);

    // Drop valid once the sender has nothing more to offer.
    task automatic idle_input();
        in_valid <= 1'b0;
    endtask

    // Present one beat, holding it until it is taken; idle first at random.
    // Called and returns at a falling edge; valid is left high so that a
    // following beat can go straight out.
    task automatic send_beat(logic [7:0] b, logic hb, logic lst);
        while (!steady && $urandom_range(99) < 26)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_item  <= '{data_byte: b, has_byte: hb, is_last: lst};
        in_valid <= 1'b1;
        while (!in_ready) @(negedge clk);
        @(posedge clk);
        @(negedge clk);
        beats_sent++;
    endtask

    // A whole message of n random bytes; the last byte may carry is_last,
    // or a byteless closing beat ends it.
    task automatic send_message(int n, bit byteless_end);
        for (int i = 0; i < n; i++)
            send_beat(8'($urandom), 1'b1, (i == n - 1) && !byteless_end);
        if (byteless_end || n == 0) send_beat(8'($urandom), 1'b0, 1'b1);
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: empty message, stray byteless beat, short messages.
        send_beat(8'hFF, 1'b0, 1'b0);
        send_message(0, 1'b1);
        send_beat(8'h00, 1'b1, 1'b1);
        send_beat(8'hFF, 1'b1, 1'b0);
        send_beat(8'h00, 1'b0, 1'b1);
        send_message(3, 1'b0);

        // Hold until every digest word is back.
        idle_input();
        while (words_pending != 0) @(negedge clk);

        // Block-boundary lengths: 55 pads within one block; 56 and up spill into a second.
        foreach (boundary_lens[i])
            send_message(boundary_lens[i], 1'($urandom_range(1)));

        // No-gap stretch.
        steady = 1'b1;
        send_message(20, 1'b0);
        steady = 1'b0;

        // Random messages, mostly short, some spanning blocks, with noise.
        while (beats_sent < 410)
        begin
            if ($urandom_range(9) == 0)
                send_beat(8'($urandom), 1'b0, 1'b0);
            else if ($urandom_range(7) == 0)
                send_message(int'($urandom_range(50, 130)), 1'($urandom_range(1)));
            else
                send_message(int'($urandom_range(0, 12)), $urandom_range(3) == 0);
        end
        idle_input();

        while (words_pending != 0) @(posedge clk);
        repeat (200) @(posedge clk);

        $display("Sent %0d input beats and checked %0d digests,", beats_sent,
                 digests_seen);
        $display("including empty, block-edge and multi-block messages.");
        if (fail_count == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule

@@ sim.f @@
hdl/sha1_pkg.sv
hdl/sha1_front.sv
hdl/sha1_back.sv
hdl/sha1_digest_engine_top.sv
test/sha1_digest_checker.sv
test/tb_top.sv
